FILE: design/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg: shared types and constants for the bicubic patch evaluator
// Beat layouts, coefficient store geometry, Horner step decode and
// output saturation.
// ----------------------------------------------------------------------------
package bpe_pkg;

   // Grid and store geometry
   localparam int GRID_SQUARES_X1  = 4;
   localparam int GRID_SQUARES_X2  = 4;
   localparam int NUM_TABLES       = 4;
   localparam int COEFS_PER_SQUARE = 16;
   localparam int STORE_DEPTH      = NUM_TABLES * GRID_SQUARES_X1 * GRID_SQUARES_X2
                                     * COEFS_PER_SQUARE;
   localparam int STORE_AW         = $clog2(STORE_DEPTH);

   // Number formats
   localparam int COORD_W = 20;
   localparam int FRAC_W  = 16;
   localparam int COEF_W  = 32;
   localparam int ACC_W   = 40;

   // Horner sequence: thirteen steps per row, four rows
   localparam logic [3:0] LAST_STEP = 4'd12;
   localparam logic [1:0] FIRST_ROW = 2'd3;
   localparam logic [1:0] LAST_ROW  = 2'd0;

   // Operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [1:0]         table_select;
      logic [1:0]         square_x1;
      logic [1:0]         square_x2;
      logic [3:0]         coef_index;
      logic signed [31:0] coef_value;
      logic [19:0]        x1_coord;
      logic [19:0]        x2_coord;
   } bpe_req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] deriv_x1;
      logic signed [31:0] deriv_x2;
      logic               saturated;
   } bpe_rsp_type;

   // Accumulator selection
   typedef enum logic [1:0] {
      ACC_TMP = 2'd0,
      ACC_Y   = 2'd1,
      ACC_D1  = 2'd2,
      ACC_D2  = 2'd3
   } bpe_acc_sel_type;

   // Addend selection
   typedef enum logic [1:0] {
      ADD_COEF1 = 2'd0,
      ADD_COEF2 = 2'd1,
      ADD_COEF3 = 2'd2,
      ADD_TMP   = 2'd3
   } bpe_add_sel_type;

   // One multiply-add step: dst = ((src * f) >>> 16) + addend
   typedef struct packed {
      bpe_acc_sel_type src;
      logic            src_zero;
      logic            use_ft;
      bpe_add_sel_type add;
      bpe_acc_sel_type dst;
      logic [3:0]      coef_idx;
   } bpe_step_type;

   typedef struct packed {
      logic         valid;
      logic         clear;
      bpe_step_type step;
   } bpe_mac_ctl_type;

   // Start address of one square's coefficients
   function automatic logic [STORE_AW-1:0] store_base(input logic [1:0] tab,
                                                      input logic [3:0] s1,
                                                      input logic [3:0] s2);
      logic [31:0] idx;
      idx = ((32'(tab) * GRID_SQUARES_X1 + 32'(s1)) * GRID_SQUARES_X2 + 32'(s2))
            * COEFS_PER_SQUARE;
      return idx[STORE_AW-1:0];
   endfunction

   // Decode step j of row r
   function automatic bpe_step_type step_decode(input logic [3:0] j, input logic [1:0] r);
      bpe_step_type s;
      s.src      = ACC_TMP;
      s.src_zero = 1'b0;
      s.use_ft   = 1'b0;
      s.add      = ADD_COEF1;
      s.dst      = ACC_TMP;
      s.coef_idx = {r, 2'd3};
      case (j)
         4'd0: begin
            s.src_zero = 1'b1;
         end
         4'd1: begin
            s.coef_idx = {r, 2'd2};
         end
         4'd2: begin
            s.coef_idx = {r, 2'd1};
         end
         4'd3: begin
            s.coef_idx = {r, 2'd0};
         end
         4'd4: begin
            s.src    = ACC_Y;
            s.use_ft = 1'b1;
            s.add    = ADD_TMP;
            s.dst    = ACC_Y;
         end
         4'd5: begin
            s.src_zero = 1'b1;
            s.add      = ADD_COEF3;
         end
         4'd6: begin
            s.add      = ADD_COEF2;
            s.coef_idx = {r, 2'd2};
         end
         4'd7: begin
            s.coef_idx = {r, 2'd1};
         end
         4'd8: begin
            s.src    = ACC_D2;
            s.use_ft = 1'b1;
            s.add    = ADD_TMP;
            s.dst    = ACC_D2;
         end
         4'd9: begin
            s.src_zero = 1'b1;
            s.add      = ADD_COEF3;
            s.coef_idx = {2'd3, r};
         end
         4'd10: begin
            s.use_ft   = 1'b1;
            s.add      = ADD_COEF2;
            s.coef_idx = {2'd2, r};
         end
         4'd11: begin
            s.use_ft   = 1'b1;
            s.coef_idx = {2'd1, r};
         end
         4'd12: begin
            s.src = ACC_D1;
            s.add = ADD_TMP;
            s.dst = ACC_D1;
         end
         default: begin
            s.src_zero = 1'b1;
         end
      endcase
      return s;
   endfunction

   // Clip to signed 32 bits; bit 32 flags a clip
   function automatic logic [32:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(64'sd2147483647);
      lo = -ACC_W'(64'sd2147483648);
      if (v > hi) begin
         return {1'b1, 32'h7FFF_FFFF};
      end else if (v < lo) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, v[31:0]};
   endfunction

endpackage

FILE: design/bicubic_patch_evaluator.sv
// ----------------------------------------------------------------------------
// bicubic_patch_evaluator: bicubic value and gradient on stored patches
// Keeps 4x4 coefficient matrices per grid square and evaluates the patch
// and both partial derivatives by Horner's rule.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per item: a coefficient write or an evaluate.
//   rsp_* carries one beat per evaluate: value, both derivatives, clip flag.
//   A write gives no response beat.
//   An evaluate runs 52 multiply-add steps on the single shared multiplier,
//   one step per cycle, with the coefficient RAM read one step ahead; rsp_valid
//   rises after the EVAL, DRAIN and FINISH states and req_stall drops in the same
//   cycle, so no new evaluate is taken until the last one is done. An evaluate of
//   a missing table goes straight to FINISH and raises rsp_valid with zeros.
//   req_stall is high while an evaluate is in progress.
//   A response waits in the output register under rsp_stall while the next
//   request is taken; a finished evaluate holds until that register frees.
//   Reset clears control state only; coefficients are undefined until
//   written, and must be written before they are evaluated.
// ----------------------------------------------------------------------------
module bicubic_patch_evaluator import bpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  bpe_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output bpe_rsp_type rsp_payload
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EVAL   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } bpe_state_type;

   localparam logic [COORD_W-1:0] MAX_X1 = COORD_W'(GRID_SQUARES_X1 * 65536 - 1);
   localparam logic [COORD_W-1:0] MAX_X2 = COORD_W'(GRID_SQUARES_X2 * 65536 - 1);

   bpe_state_type         state_ff, state_in;
   logic [3:0]            j_ff, j_in;
   logic [1:0]            r_ff, r_in;
   logic [FRAC_W-1:0]     ft_ff, ft_in, fu_ff, fu_in;
   logic [STORE_AW-1:0]   base_ff, base_in;
   logic                  bad_ff, bad_in;
   bpe_mac_ctl_type       exec_ctl_ff, exec_ctl_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bpe_rsp_type           rsp_payload_ff, rsp_payload_in;

   logic                  req_accept;
   logic                  is_eval;
   logic                  wr_ok;
   logic                  ram_we;
   logic [STORE_AW-1:0]   wr_addr;
   logic [COORD_W-1:0]    x1c, x2c;
   bpe_step_type          cur_step;
   logic [STORE_AW-1:0]   rd_addr;
   logic [COEF_W-1:0]     rd_data;
   logic signed [ACC_W-1:0] acc_y, acc_d1, acc_d2;
   logic [32:0]           sat_y, sat_d1, sat_d2;
   logic                  rsp_free;

   // Accept a request beat only when idle
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign is_eval    = (req_payload.operation == OP_EVAL);

   // Coefficient write address and range check
   assign wr_ok   = (32'(req_payload.table_select) < NUM_TABLES)
                 && (32'(req_payload.square_x1) < GRID_SQUARES_X1)
                 && (32'(req_payload.square_x2) < GRID_SQUARES_X2);
   assign ram_we  = req_accept && !is_eval && wr_ok;
   assign wr_addr = store_base(req_payload.table_select, {2'b00, req_payload.square_x1},
                               {2'b00, req_payload.square_x2})
                  + STORE_AW'(req_payload.coef_index);

   // Clamp coordinates to just below the grid edge
   assign x1c = (req_payload.x1_coord > MAX_X1) ? MAX_X1 : req_payload.x1_coord;
   assign x2c = (req_payload.x2_coord > MAX_X2) ? MAX_X2 : req_payload.x2_coord;

   // Coefficient fetch for the step being issued
   assign cur_step = step_decode(j_ff, r_ff);
   assign rd_addr  = base_ff + STORE_AW'(cur_step.coef_idx);

   bpe_ram #(
      .WIDTH (COEF_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (req_payload.coef_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bpe_mac u_mac (
      .clock  (clock),
      .ctl    (exec_ctl_ff),
      .coef   ($signed(rd_data)),
      .ft     (ft_ff),
      .fu     (fu_ff),
      .acc_y  (acc_y),
      .acc_d1 (acc_d1),
      .acc_d2 (acc_d2)
   );

   // Saturate the final sums
   assign sat_y    = sat32(acc_y);
   assign sat_d1   = sat32(acc_d1);
   assign sat_d2   = sat32(acc_d2);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      j_in           = j_ff;
      r_in           = r_ff;
      ft_in          = ft_ff;
      fu_in          = fu_ff;
      base_in        = base_ff;
      bad_in         = bad_ff;
      exec_ctl_in    = '0;
      exec_ctl_in.step = cur_step;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_eval) begin
               ft_in   = x1c[FRAC_W-1:0];
               fu_in   = x2c[FRAC_W-1:0];
               base_in = store_base(req_payload.table_select,
                                    x1c[COORD_W-1:FRAC_W], x2c[COORD_W-1:FRAC_W]);
               j_in    = '0;
               r_in    = FIRST_ROW;
               if (32'(req_payload.table_select) < NUM_TABLES) begin
                  bad_in            = 1'b0;
                  exec_ctl_in.clear = 1'b1;
                  state_in          = ST_EVAL;
               end else begin
                  bad_in   = 1'b1;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_EVAL: begin
            // Issue one step; it executes next cycle with the fetched coefficient
            exec_ctl_in.valid = 1'b1;
            if (j_ff == LAST_STEP) begin
               j_in = '0;
               if (r_ff == LAST_ROW) begin
                  state_in = ST_DRAIN;
               end else begin
                  r_in = r_ff - 2'd1;
               end
            end else begin
               j_in = j_ff + 4'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // Load the output register once it is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (bad_ff) begin
                  rsp_payload_in = '0;
               end else begin
                  rsp_payload_in.value     = sat_y[31:0];
                  rsp_payload_in.deriv_x1  = sat_d1[31:0];
                  rsp_payload_in.deriv_x2  = sat_d2[31:0];
                  rsp_payload_in.saturated = sat_y[32] | sat_d1[32] | sat_d2[32];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         j_ff         <= '0;
         r_ff         <= FIRST_ROW;
         exec_ctl_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         r_ff         <= r_in;
         exec_ctl_ff  <= exec_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
         bad_ff       <= bad_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ft_ff          <= ft_in;
      fu_ff          <= fu_in;
      base_ff        <= base_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Coefficient writes happen only while idle
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE))
      else $error("coefficient write outside idle");

   // Multiply-add steps execute only right after an issue
   assert property (@(posedge clock) disable iff (reset)
      exec_ctl_ff.valid |-> (state_ff == ST_EVAL || state_ff == ST_DRAIN))
      else $error("step executed outside evaluation");

   // Drain follows the last step of the last row
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && j_ff == LAST_STEP && r_ff == LAST_ROW) |=>
      (state_ff == ST_DRAIN))
      else $error("sequence did not drain after the last step");

   // Leaving finish always loads a response beat
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free) |=> rsp_valid_ff)
      else $error("finished evaluate produced no response beat");

endmodule

FILE: design/bpe_ram.sv
// ----------------------------------------------------------------------------
// bpe_ram: generic single write, single read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bpe_mac.sv
// ----------------------------------------------------------------------------
// bpe_mac: shared multiply-add unit with Horner accumulators
// Each step scales one accumulator by t or u in Q.16, floors, and adds a
// scaled coefficient or the temporary partial sum.
// ----------------------------------------------------------------------------
module bpe_mac import bpe_pkg::*; (
   input  logic                    clock,
   input  bpe_mac_ctl_type         ctl,
   input  logic signed [COEF_W-1:0] coef,
   input  logic [FRAC_W-1:0]       ft,
   input  logic [FRAC_W-1:0]       fu,
   output logic signed [ACC_W-1:0] acc_y,
   output logic signed [ACC_W-1:0] acc_d1,
   output logic signed [ACC_W-1:0] acc_d2
);

   localparam int PROD_W = ACC_W + FRAC_W + 1;

   logic signed [ACC_W-1:0]  tmp_ff, y_ff, d1_ff, d2_ff;
   logic signed [ACC_W-1:0]  mul_a;
   logic [FRAC_W-1:0]        mul_f;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  scaled;
   logic signed [ACC_W-1:0]  coef_ext;
   logic signed [ACC_W-1:0]  addend;
   logic signed [ACC_W-1:0]  sum;

   // Select multiplicand and fraction
   always_comb begin
      case (ctl.step.src)
         ACC_TMP: mul_a = tmp_ff;
         ACC_Y:   mul_a = y_ff;
         ACC_D1:  mul_a = d1_ff;
         ACC_D2:  mul_a = d2_ff;
         default: mul_a = tmp_ff;
      endcase
      if (ctl.step.src_zero) begin
         mul_a = '0;
      end
      mul_f = ctl.step.use_ft ? ft : fu;
   end

   // Multiply and floor by arithmetic shift
   assign prod   = mul_a * $signed({1'b0, mul_f});
   assign scaled = ACC_W'(prod >>> FRAC_W);

   // Select addend: coefficient times one, two or three, or the partial sum
   assign coef_ext = ACC_W'(coef);
   always_comb begin
      case (ctl.step.add)
         ADD_COEF1: addend = coef_ext;
         ADD_COEF2: addend = coef_ext <<< 1;
         ADD_COEF3: addend = coef_ext + (coef_ext <<< 1);
         ADD_TMP:   addend = tmp_ff;
         default:   addend = coef_ext;
      endcase
   end

   assign sum = scaled + addend;

   // Clear the result accumulators, or update the destination accumulator
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         y_ff  <= '0;
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (ctl.valid) begin
         case (ctl.step.dst)
            ACC_TMP: tmp_ff <= sum;
            ACC_Y:   y_ff   <= sum;
            ACC_D1:  d1_ff  <= sum;
            ACC_D2:  d2_ff  <= sum;
            default: tmp_ff <= sum;
         endcase
      end
   end

   assign acc_y  = y_ff;
   assign acc_d1 = d1_ff;
   assign acc_d2 = d2_ff;

endmodule
